// ----- rtl/mqrr_pkg.sv -----
// Shared types and codes of the multi-queue round-robin transmit scheduler.
// No dependencies; every other file but mqrr_ram refers to this package by scoped names.
package mqrr_pkg;

    localparam logic [3:0] HDR_BYTES    = 4'd10;
    localparam logic [3:0] MIN_WIRE_LEN = 4'd14;

    // Config register indexes.
    localparam logic [1:0] REG_ACCEL      = 2'd0;
    localparam logic [1:0] REG_PKT_LIMIT  = 2'd1;
    localparam logic [1:0] REG_BYTE_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        OP_SUBMIT = 3'd0,
        OP_PULL   = 3'd1,
        OP_STATUS = 3'd2,
        OP_DONE   = 3'd3,
        OP_FLUSH  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        SEND_ACCEPTED = 2'd0,
        SEND_DEFERRED = 2'd1,
        SEND_FAILED   = 2'd2
    } send_t;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_ENQ     = 3'd1,
        ST_DROP    = 3'd2,
        ST_INVALID = 3'd3,
        ST_OUT     = 3'd4,
        ST_EMPTY   = 3'd5,
        ST_BLOCKED = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CMD_SUBMIT,
        CMD_PULL,
        CMD_STATUS,
        CMD_DONE,
        CMD_FLUSH,
        CMD_INVALID,
        CMD_BADOP
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_QRD,
        BK_DRD
    } back_state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  queue_index;
        logic [15:0] packet_length;
        logic [15:0] packet_tag;
        logic [1:0]  send_status;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  out_queue;
        logic [16:0] out_length;
        logic [15:0] out_tag;
        logic [31:0] packets_total;
        logic [31:0] dropped_total;
        logic [31:0] invalid_total;
        logic [31:0] flush_dropped_total;
    } out_word_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  queue_index;
        logic [16:0] stored_len;
        logic [15:0] tag;
        logic [1:0]  send_status;
    } cmd_t;

endpackage

// ----- rtl/mqrr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mqrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/mqrr_front.sv -----
// Front end: checks and classifies an incoming word into a command.
// Depends on mqrr_pkg.
module mqrr_front #(
    parameter int NUM_QUEUES = 64
) (
    input  logic               accelerated_mode,
    input  mqrr_pkg::in_word_t in_word,
    output mqrr_pkg::cmd_t     cmd
);
    logic bad_index;
    logic bad_len;

    assign bad_index = {1'b0, in_word.queue_index} >= 9'(NUM_QUEUES);
    assign bad_len   = in_word.packet_length < 16'(mqrr_pkg::MIN_WIRE_LEN);

    always_comb begin
        cmd.queue_index = in_word.queue_index;
        cmd.tag         = in_word.packet_tag;
        cmd.send_status = in_word.send_status;
        cmd.stored_len  = {1'b0, in_word.packet_length}
                        + (accelerated_mode ? 17'(mqrr_pkg::HDR_BYTES) : 17'd0);
        unique case (mqrr_pkg::op_t'(in_word.op))
            mqrr_pkg::OP_SUBMIT: begin
                cmd.kind = (bad_index || bad_len) ? mqrr_pkg::CMD_INVALID
                                                  : mqrr_pkg::CMD_SUBMIT;
            end
            mqrr_pkg::OP_PULL:   cmd.kind = mqrr_pkg::CMD_PULL;
            mqrr_pkg::OP_STATUS: cmd.kind = mqrr_pkg::CMD_STATUS;
            mqrr_pkg::OP_DONE:   cmd.kind = mqrr_pkg::CMD_DONE;
            mqrr_pkg::OP_FLUSH:  cmd.kind = mqrr_pkg::CMD_FLUSH;
            default:             cmd.kind = mqrr_pkg::CMD_BADOP;
        endcase
    end
endmodule

// ----- rtl/mqrr_cmd_fifo.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on mqrr_pkg.
module mqrr_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mqrr_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output mqrr_pkg::cmd_t pop_data
);
    mqrr_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ----- rtl/mqrr_back.sv -----
// Back end: per-queue state, descriptor store, round-robin pick and counters.
// Depends on mqrr_pkg and mqrr_ram.
module mqrr_back #(
    parameter int NUM_QUEUES  = 64,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [8:0]          queue_packet_limit,
    input  logic [22:0]         queue_byte_limit,
    input  logic                cmd_valid,
    input  mqrr_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output mqrr_pkg::out_word_t m_data
);
    localparam int QIW    = $clog2(NUM_QUEUES);
    localparam int PW     = $clog2(QUEUE_DEPTH);
    localparam int FW     = $clog2(QUEUE_DEPTH + 1);
    localparam int BW     = 24;
    localparam int QSW    = 2 * PW + FW + BW;
    localparam int DDEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int DAW    = $clog2(DDEPTH);
    localparam int TW     = $clog2(DDEPTH + 1);
    localparam int CW     = ((FW > 9) ? FW : 9) + 1;

    mqrr_pkg::back_state_t state_reg, state_next;
    mqrr_pkg::cmd_t        cmd_reg, cmd_next;
    logic [QIW-1:0]        q_reg, q_next;
    logic [QSW-1:0]        qs_reg, qs_next;
    logic [NUM_QUEUES-1:0] qvalid_reg, qvalid_next;
    logic [NUM_QUEUES-1:0] busy_reg, busy_next;
    logic [QIW-1:0]        rr_reg, rr_next;
    logic                  pending_reg, pending_next;
    logic [TW-1:0]         total_reg, total_next;
    logic [31:0]           cnt_pkt_reg, cnt_pkt_next;
    logic [31:0]           cnt_drop_reg, cnt_drop_next;
    logic [31:0]           cnt_inv_reg, cnt_inv_next;
    logic [31:0]           cnt_flush_reg, cnt_flush_next;
    logic                  m_valid_reg, m_valid_next;
    mqrr_pkg::out_word_t   m_data_reg, m_data_next;

    logic                  out_free;
    logic                  start;
    logic [QIW-1:0]        sel_hi, sel_any, pick;
    logic                  found_hi, found_any;

    logic                  qram_we;
    logic [QIW-1:0]        qram_raddr;
    logic [QSW-1:0]        qram_wdata, qram_rdata, qs_rd;
    logic                  dram_we;
    logic [DAW-1:0]        dram_waddr, dram_raddr;
    logic [32:0]           dram_wdata, dram_rdata;

    logic [PW-1:0]         rd_head, rd_tail, st_head, st_tail;
    logic [FW-1:0]         rd_fill, st_fill;
    logic [BW-1:0]         rd_bytes, st_bytes;
    logic [DAW-1:0]        q_base;

    logic                  over;
    logic [16:0]           res_len;
    logic [15:0]           res_tag;
    logic [5:0]            res_queue;
    mqrr_pkg::status_t     res_status;
    logic                  res_valid;

    assign out_free = !m_valid_reg || m_ready;
    assign start    = (state_reg == mqrr_pkg::BK_IDLE) && cmd_valid && out_free;
    assign cmd_pop  = start;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Round robin: lowest busy queue at or past the pointer, else lowest busy.
    always_comb begin
        sel_hi    = '0;
        sel_any   = '0;
        found_hi  = 1'b0;
        found_any = 1'b0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
            if (busy_reg[i]) begin
                sel_any   = QIW'(i);
                found_any = 1'b1;
                if (QIW'(i) >= rr_reg) begin
                    sel_hi   = QIW'(i);
                    found_hi = 1'b1;
                end
            end
        end
        pick = found_hi ? sel_hi : sel_any;
    end

    assign qs_rd = qvalid_reg[q_reg] ? qram_rdata : '0;
    assign {rd_head, rd_tail, rd_fill, rd_bytes} = qs_rd;
    assign {st_head, st_tail, st_fill, st_bytes} = qs_reg;
    assign q_base     = DAW'(q_reg) * DAW'(QUEUE_DEPTH);
    assign qram_raddr = (cmd.kind == mqrr_pkg::CMD_PULL) ? pick
                                                         : cmd.queue_index[QIW-1:0];
    assign dram_raddr = q_base + DAW'(rd_head);
    assign over = (CW'(rd_fill) + CW'(1) > CW'(queue_packet_limit))
               || (CW'(rd_fill) + CW'(1) > CW'(QUEUE_DEPTH))
               || (25'(rd_bytes) + 25'(cmd_reg.stored_len) > 25'(queue_byte_limit));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mqrr_pkg::BK_IDLE: begin
                if (start && (cmd.kind == mqrr_pkg::CMD_SUBMIT
                    || (cmd.kind == mqrr_pkg::CMD_PULL && !pending_reg && found_any))) begin
                    state_next = mqrr_pkg::BK_QRD;
                end
            end
            mqrr_pkg::BK_QRD: begin
                state_next = (cmd_reg.kind == mqrr_pkg::CMD_PULL) ? mqrr_pkg::BK_DRD
                                                                  : mqrr_pkg::BK_IDLE;
            end
            mqrr_pkg::BK_DRD: state_next = mqrr_pkg::BK_IDLE;
            default:          state_next = mqrr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_next       = cmd_reg;
        q_next         = q_reg;
        qs_next        = qs_reg;
        qvalid_next    = qvalid_reg;
        busy_next      = busy_reg;
        rr_next        = rr_reg;
        pending_next   = pending_reg;
        total_next     = total_reg;
        cnt_pkt_next   = cnt_pkt_reg;
        cnt_drop_next  = cnt_drop_reg;
        cnt_inv_next   = cnt_inv_reg;
        cnt_flush_next = cnt_flush_reg;
        qram_we        = 1'b0;
        qram_wdata     = qs_rd;
        dram_we        = 1'b0;
        dram_waddr     = q_base + DAW'(rd_tail);
        dram_wdata     = {cmd_reg.stored_len, cmd_reg.tag};
        res_valid      = 1'b0;
        res_status     = mqrr_pkg::ST_DONE;
        res_queue      = '0;
        res_len        = '0;
        res_tag        = '0;

        unique case (state_reg)
            mqrr_pkg::BK_IDLE: begin
                if (start) begin
                    cmd_next = cmd;
                    q_next   = qram_raddr;
                    unique case (cmd.kind)
                        mqrr_pkg::CMD_SUBMIT: ;
                        mqrr_pkg::CMD_PULL: begin
                            if (pending_reg) begin
                                res_valid  = 1'b1;
                                res_status = mqrr_pkg::ST_BLOCKED;
                            end else if (!found_any) begin
                                res_valid  = 1'b1;
                                res_status = mqrr_pkg::ST_EMPTY;
                            end
                        end
                        mqrr_pkg::CMD_STATUS: begin
                            pending_next = cmd.send_status == mqrr_pkg::SEND_DEFERRED;
                            if (cmd.send_status == mqrr_pkg::SEND_FAILED) begin
                                cnt_drop_next = cnt_drop_reg + 32'd1;
                            end
                            res_valid = 1'b1;
                        end
                        mqrr_pkg::CMD_DONE: begin
                            pending_next = 1'b0;
                            res_valid    = 1'b1;
                        end
                        mqrr_pkg::CMD_FLUSH: begin
                            cnt_flush_next = cnt_flush_reg + 32'(total_reg)
                                           + {31'd0, pending_reg};
                            qvalid_next    = '0;
                            busy_next      = '0;
                            total_next     = '0;
                            rr_next        = '0;
                            pending_next   = 1'b0;
                            res_valid      = 1'b1;
                        end
                        mqrr_pkg::CMD_INVALID: begin
                            cnt_inv_next = cnt_inv_reg + 32'd1;
                            res_valid    = 1'b1;
                            res_status   = mqrr_pkg::ST_INVALID;
                        end
                        default: begin
                            res_valid  = 1'b1;
                            res_status = mqrr_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            mqrr_pkg::BK_QRD: begin
                qs_next = qs_rd;
                if (cmd_reg.kind == mqrr_pkg::CMD_SUBMIT) begin
                    res_valid = 1'b1;
                    if (over) begin
                        cnt_drop_next = cnt_drop_reg + 32'd1;
                        res_status    = mqrr_pkg::ST_DROP;
                    end else begin
                        dram_we    = 1'b1;
                        qram_we    = 1'b1;
                        qram_wdata = {rd_head,
                                      (rd_tail == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_tail + PW'(1),
                                      rd_fill + FW'(1),
                                      rd_bytes + BW'(cmd_reg.stored_len)};
                        qvalid_next[q_reg] = 1'b1;
                        busy_next[q_reg]   = 1'b1;
                        total_next   = total_reg + TW'(1);
                        cnt_pkt_next = cnt_pkt_reg + 32'd1;
                        res_status   = mqrr_pkg::ST_ENQ;
                    end
                end
            end
            mqrr_pkg::BK_DRD: begin
                qram_we    = 1'b1;
                qram_wdata = {(st_head == PW'(QUEUE_DEPTH - 1)) ? '0 : st_head + PW'(1),
                              st_tail,
                              st_fill - FW'(1),
                              st_bytes - BW'(dram_rdata[32:16])};
                busy_next[q_reg] = st_fill != FW'(1);
                total_next = total_reg - TW'(1);
                rr_next    = (q_reg == QIW'(NUM_QUEUES - 1)) ? '0 : q_reg + QIW'(1);
                res_valid  = 1'b1;
                res_status = mqrr_pkg::ST_OUT;
                res_queue  = 6'(q_reg);
                res_len    = dram_rdata[32:16];
                res_tag    = dram_rdata[15:0];
            end
            default: ;
        endcase

        m_valid_next = (m_valid_reg && !m_ready) || res_valid;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            m_data_next.status              = res_status;
            m_data_next.out_queue           = res_queue;
            m_data_next.out_length          = res_len;
            m_data_next.out_tag             = res_tag;
            m_data_next.packets_total       = cnt_pkt_next;
            m_data_next.dropped_total       = cnt_drop_next;
            m_data_next.invalid_total       = cnt_inv_next;
            m_data_next.flush_dropped_total = cnt_flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mqrr_pkg::BK_IDLE;
            qvalid_reg    <= '0;
            busy_reg      <= '0;
            rr_reg        <= '0;
            pending_reg   <= 1'b0;
            total_reg     <= '0;
            cnt_pkt_reg   <= '0;
            cnt_drop_reg  <= '0;
            cnt_inv_reg   <= '0;
            cnt_flush_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            qvalid_reg    <= qvalid_next;
            busy_reg      <= busy_next;
            rr_reg        <= rr_next;
            pending_reg   <= pending_next;
            total_reg     <= total_next;
            cnt_pkt_reg   <= cnt_pkt_next;
            cnt_drop_reg  <= cnt_drop_next;
            cnt_inv_reg   <= cnt_inv_next;
            cnt_flush_reg <= cnt_flush_next;
            m_valid_reg   <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        q_reg      <= q_next;
        qs_reg     <= qs_next;
        m_data_reg <= m_data_next;
    end

    mqrr_ram #(.WIDTH(QSW), .DEPTH(NUM_QUEUES)) u_qstate_ram (
        .aclk  (aclk),
        .we    (qram_we),
        .waddr (q_reg),
        .wdata (qram_wdata),
        .raddr (qram_raddr),
        .rdata (qram_rdata)
    );

    mqrr_ram #(.WIDTH(33), .DEPTH(DDEPTH)) u_desc_ram (
        .aclk  (aclk),
        .we    (dram_we),
        .waddr (dram_waddr),
        .wdata (dram_wdata),
        .raddr (dram_raddr),
        .rdata (dram_rdata)
    );
endmodule

// ----- rtl/multi_queue_round_robin_tx.sv -----
// Top level of the multi-queue round-robin transmit scheduler with tail drop.
// Depends on mqrr_pkg, mqrr_front, mqrr_cmd_fifo, mqrr_back and mqrr_ram.
//
//   channel   direction  handshake             word
//   s_        in         s_valid / s_ready     mqrr_pkg::in_word_t
//   m_        out        m_valid / m_ready     mqrr_pkg::out_word_t
//   cfg_      in         cfg_wr_en (no wait)   index 0..2, 23-bit data
//
// Steps: status-only words (send status, send done, flush, invalid, blocked,
// all empty) end in the back end's idle state; submit is a queue state read,
// then the update; pull is a queue state read, a descriptor read, then the
// update. The per-queue state RAM read-modify-write sets these steps.
// Reset: aresetn is synchronous, active low; no clearing pass is needed since
// per-queue valid bits make untouched queues read as empty.
// Stalls: a two-word command queue decouples s_ from the back end, and the
// back end waits only while a finished result is still held on m_.
module multi_queue_round_robin_tx #(
    parameter int NUM_QUEUES  = 64,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mqrr_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mqrr_pkg::out_word_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [22:0]         cfg_wr_data
);
    logic           accel_reg, accel_next;
    logic [8:0]     pkt_limit_reg, pkt_limit_next;
    logic [22:0]    byte_limit_reg, byte_limit_next;

    mqrr_pkg::cmd_t front_cmd, fifo_cmd;
    logic           fifo_full, fifo_not_empty, fifo_pop;

    // Hold config registers; take a write only at a matching index.
    always_comb begin
        accel_next      = accel_reg;
        pkt_limit_next  = pkt_limit_reg;
        byte_limit_next = byte_limit_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                mqrr_pkg::REG_ACCEL:      accel_next      = cfg_wr_data[0];
                mqrr_pkg::REG_PKT_LIMIT:  pkt_limit_next  = cfg_wr_data[8:0];
                mqrr_pkg::REG_BYTE_LIMIT: byte_limit_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg      <= 1'b0;
            pkt_limit_reg  <= 9'd256;
            byte_limit_reg <= 23'd4194304;
        end else begin
            accel_reg      <= accel_next;
            pkt_limit_reg  <= pkt_limit_next;
            byte_limit_reg <= byte_limit_next;
        end
    end

    // Accept a word whenever the command queue has room.
    assign s_ready = !fifo_full;

    mqrr_front #(.NUM_QUEUES(NUM_QUEUES)) u_front (
        .accelerated_mode (accel_reg),
        .in_word          (s_data),
        .cmd              (front_cmd)
    );

    mqrr_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_data (front_cmd),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .pop_data  (fifo_cmd)
    );

    mqrr_back #(.NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .queue_packet_limit (pkt_limit_reg),
        .queue_byte_limit   (byte_limit_reg),
        .cmd_valid          (fifo_not_empty),
        .cmd                (fifo_cmd),
        .cmd_pop            (fifo_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data             (m_data)
    );
endmodule
